// ===== hdl/rv64_dex_pkg.sv =====
package rv64_dex_pkg;

  localparam int XLEN = 64;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OPW    = 7'h3B;
  localparam logic [6:0] OPC_OPIMMW = 7'h1B;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;

  localparam logic [3:0] ALU_ADD  = 4'd0;
  localparam logic [3:0] ALU_SUB  = 4'd1;
  localparam logic [3:0] ALU_SLL  = 4'd2;
  localparam logic [3:0] ALU_SLT  = 4'd3;
  localparam logic [3:0] ALU_XOR  = 4'd4;
  localparam logic [3:0] ALU_SRL  = 4'd5;
  localparam logic [3:0] ALU_SRA  = 4'd6;
  localparam logic [3:0] ALU_OR   = 4'd7;
  localparam logic [3:0] ALU_AND  = 4'd8;
  localparam logic [3:0] ALU_ADDW = 4'd9;
  localparam logic [3:0] ALU_SUBW = 4'd10;
  localparam logic [3:0] ALU_PASS = 4'd11;

  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;

  localparam logic [XLEN-1:0] INSN_BYTES = 64'd4;

  typedef struct packed {
    logic [31:0]            instruction_word;
    logic [XLEN-1:0]        pc;
    logic signed [XLEN-1:0] rs1_value;
    logic signed [XLEN-1:0] rs2_value;
  } in_item_t;

  typedef struct packed {
    logic signed [XLEN-1:0] result_value;
    logic                   write_enable;
    logic [4:0]             dest_reg;
    logic                   load_request;
    logic                   store_request;
    logic [XLEN-1:0]        mem_address;
    logic signed [XLEN-1:0] store_data;
    logic                   branch_taken;
    logic [XLEN-1:0]        branch_target;
  } out_item_t;

  typedef struct packed {
    logic [3:0]      alu_op;
    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] op_b;
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] rs2;
    logic [4:0]      rd;
    logic            we;
    logic            ld;
    logic            st;
    logic            is_br;
    logic [2:0]      br_cond;
    logic            is_jal;
    logic            is_jalr;
  } dec_t;

endpackage

// ===== hdl/rv64_dex_decode.sv =====
module rv64_dex_decode (
  input  logic                  clk,
  input  logic                  en,
  input  rv64_dex_pkg::in_item_t item,
  output rv64_dex_pkg::dec_t    dec_r
);

  rv64_dex_pkg::dec_t dec_nxt;
  logic [31:0] iw;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [63:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic        ok;

  always_comb begin
    iw    = item.instruction_word;
    opc   = iw[6:0];
    f3    = iw[14:12];
    f7    = iw[31:25];
    imm_i = {{52{iw[31]}}, iw[31:20]};
    imm_s = {{52{iw[31]}}, iw[31:25], iw[11:7]};
    imm_b = {{52{iw[31]}}, iw[7], iw[30:25], iw[11:8], 1'b0};
    imm_u = {{32{iw[31]}}, iw[31:12], 12'd0};
    imm_j = {{44{iw[31]}}, iw[19:12], iw[20], iw[30:21], 1'b0};
    ok = 1'b1;
    dec_nxt = '0;
    dec_nxt.op_a = item.rs1_value;
    dec_nxt.op_b = item.rs2_value;
    dec_nxt.pc = item.pc;
    dec_nxt.rs2 = item.rs2_value;
    dec_nxt.rd = iw[11:7];
    dec_nxt.br_cond = f3;
    case (opc)
      rv64_dex_pkg::OPC_OP: begin
        dec_nxt.we = 1'b1;
        if (f7 == 7'h00) begin
          case (f3)
            3'd0: dec_nxt.alu_op = rv64_dex_pkg::ALU_ADD;
            3'd1: dec_nxt.alu_op = rv64_dex_pkg::ALU_SLL;
            3'd2: dec_nxt.alu_op = rv64_dex_pkg::ALU_SLT;
            3'd4: dec_nxt.alu_op = rv64_dex_pkg::ALU_XOR;
            3'd5: dec_nxt.alu_op = rv64_dex_pkg::ALU_SRL;
            3'd6: dec_nxt.alu_op = rv64_dex_pkg::ALU_OR;
            3'd7: dec_nxt.alu_op = rv64_dex_pkg::ALU_AND;
            default: ok = 1'b0;
          endcase
        end else if (f7 == 7'h20 && f3 == 3'd0) begin
          dec_nxt.alu_op = rv64_dex_pkg::ALU_SUB;
        end else if (f7 == 7'h20 && f3 == 3'd5) begin
          dec_nxt.alu_op = rv64_dex_pkg::ALU_SRA;
        end else begin
          ok = 1'b0;
        end
      end
      rv64_dex_pkg::OPC_OPIMM: begin
        dec_nxt.we = 1'b1;
        dec_nxt.op_b = imm_i;
        case (f3)
          3'd0: dec_nxt.alu_op = rv64_dex_pkg::ALU_ADD;
          3'd2: dec_nxt.alu_op = rv64_dex_pkg::ALU_SLT;
          3'd4: dec_nxt.alu_op = rv64_dex_pkg::ALU_XOR;
          3'd6: dec_nxt.alu_op = rv64_dex_pkg::ALU_OR;
          3'd7: dec_nxt.alu_op = rv64_dex_pkg::ALU_AND;
          3'd1: begin
            if (iw[31:26] == 6'd0) dec_nxt.alu_op = rv64_dex_pkg::ALU_SLL;
            else ok = 1'b0;
          end
          3'd5: begin
            if (iw[31:26] == 6'd0) dec_nxt.alu_op = rv64_dex_pkg::ALU_SRL;
            else if (iw[31:26] == 6'h10) dec_nxt.alu_op = rv64_dex_pkg::ALU_SRA;
            else ok = 1'b0;
          end
          default: ok = 1'b0;
        endcase
      end
      rv64_dex_pkg::OPC_OPW: begin
        dec_nxt.we = 1'b1;
        if (f3 == 3'd0 && f7 == 7'h00) dec_nxt.alu_op = rv64_dex_pkg::ALU_ADDW;
        else if (f3 == 3'd0 && f7 == 7'h20) dec_nxt.alu_op = rv64_dex_pkg::ALU_SUBW;
        else ok = 1'b0;
      end
      rv64_dex_pkg::OPC_OPIMMW: begin
        dec_nxt.we = 1'b1;
        dec_nxt.op_b = imm_i;
        dec_nxt.alu_op = rv64_dex_pkg::ALU_ADDW;
        if (f3 != 3'd0) ok = 1'b0;
      end
      rv64_dex_pkg::OPC_LOAD: begin
        dec_nxt.we = 1'b1;
        dec_nxt.ld = 1'b1;
        dec_nxt.imm = imm_i;
      end
      rv64_dex_pkg::OPC_STORE: begin
        dec_nxt.st = 1'b1;
        dec_nxt.imm = imm_s;
      end
      rv64_dex_pkg::OPC_BRANCH: begin
        dec_nxt.is_br = 1'b1;
        dec_nxt.imm = imm_b;
        if (f3 == 3'd2 || f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) ok = 1'b0;
      end
      rv64_dex_pkg::OPC_JAL: begin
        dec_nxt.we = 1'b1;
        dec_nxt.is_jal = 1'b1;
        dec_nxt.imm = imm_j;
        dec_nxt.alu_op = rv64_dex_pkg::ALU_PASS;
        dec_nxt.op_a = item.pc + rv64_dex_pkg::INSN_BYTES;
      end
      rv64_dex_pkg::OPC_JALR: begin
        dec_nxt.we = 1'b1;
        dec_nxt.is_jalr = 1'b1;
        dec_nxt.imm = imm_i;
        dec_nxt.alu_op = rv64_dex_pkg::ALU_PASS;
        dec_nxt.op_a = item.pc + rv64_dex_pkg::INSN_BYTES;
        dec_nxt.op_b = item.rs1_value;
        if (f3 != 3'd0) ok = 1'b0;
      end
      rv64_dex_pkg::OPC_LUI: begin
        dec_nxt.we = 1'b1;
        dec_nxt.alu_op = rv64_dex_pkg::ALU_PASS;
        dec_nxt.op_a = imm_u;
      end
      rv64_dex_pkg::OPC_AUIPC: begin
        dec_nxt.we = 1'b1;
        dec_nxt.alu_op = rv64_dex_pkg::ALU_ADD;
        dec_nxt.op_a = item.pc;
        dec_nxt.op_b = imm_u;
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      dec_nxt = '0;
    end else if (!dec_nxt.we) begin
      dec_nxt.rd = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dec_r <= dec_nxt;
  end

endmodule

// ===== hdl/rv64_dex_exec.sv =====
module rv64_dex_exec (
  input  logic                   clk,
  input  logic                   en,
  input  rv64_dex_pkg::dec_t     dec,
  output rv64_dex_pkg::out_item_t res_r
);

  rv64_dex_pkg::out_item_t res_nxt;
  logic [63:0] a, b, sum, diff, alu, ea, jt;
  logic [5:0]  sh;
  logic        lt, tk;

  always_comb begin
    a    = dec.op_a;
    b    = dec.op_b;
    sh   = b[5:0];
    sum  = a + b;
    diff = a - b;
    lt   = $signed(a) < $signed(b);
    case (dec.alu_op)
      rv64_dex_pkg::ALU_ADD:  alu = sum;
      rv64_dex_pkg::ALU_SUB:  alu = diff;
      rv64_dex_pkg::ALU_SLL:  alu = a << sh;
      rv64_dex_pkg::ALU_SLT:  alu = {63'd0, lt};
      rv64_dex_pkg::ALU_XOR:  alu = a ^ b;
      rv64_dex_pkg::ALU_SRL:  alu = a >> sh;
      rv64_dex_pkg::ALU_SRA:  alu = 64'($signed(a) >>> sh);
      rv64_dex_pkg::ALU_OR:   alu = a | b;
      rv64_dex_pkg::ALU_AND:  alu = a & b;
      rv64_dex_pkg::ALU_ADDW: alu = {{32{sum[31]}}, sum[31:0]};
      rv64_dex_pkg::ALU_SUBW: alu = {{32{diff[31]}}, diff[31:0]};
      rv64_dex_pkg::ALU_PASS: alu = a;
      default:                alu = '0;
    endcase
    ea = a + dec.imm;
    jt = dec.is_jalr ? ((b + dec.imm) & ~64'd1) : (dec.pc + dec.imm);
    case (dec.br_cond)
      rv64_dex_pkg::BR_EQ: tk = (a == b);
      rv64_dex_pkg::BR_NE: tk = (a != b);
      rv64_dex_pkg::BR_LT: tk = lt;
      rv64_dex_pkg::BR_GE: tk = !lt;
      default:             tk = 1'b0;
    endcase
    res_nxt = '0;
    res_nxt.write_enable  = dec.we;
    res_nxt.dest_reg      = dec.rd;
    res_nxt.load_request  = dec.ld;
    res_nxt.store_request = dec.st;
    if (dec.ld || dec.st) begin
      res_nxt.mem_address = ea;
      res_nxt.store_data  = dec.st ? dec.rs2 : '0;
    end else if (dec.is_br) begin
      res_nxt.branch_taken  = tk;
      res_nxt.branch_target = jt;
    end else begin
      res_nxt.result_value = alu;
      if (dec.is_jal || dec.is_jalr) begin
        res_nxt.branch_taken  = 1'b1;
        res_nxt.branch_target = jt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

endmodule

// ===== hdl/rv64i_decode_execute_unit.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid, in_stall | in_item (instruction, pc, rs1, rs2)
// out     | output    | out_valid, out_stall | out_item (nine result fields)
// Three register stages: capture, decode, execute. One item per cycle when out is not stalled.
// An accepted item passes the capture, decode and execute registers in turn before out_valid.
// Reset clears only the stage valid bits.
// A stall on out freezes only the stages that hold items ahead of a bubble.
module rv64i_decode_execute_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  rv64_dex_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output rv64_dex_pkg::out_item_t out_item
);

  logic v0_r, v1_r, v2_r;
  logic en0, en1, en2;
  rv64_dex_pkg::in_item_t s0_r;
  rv64_dex_pkg::dec_t     dec_r;

  assign en2      = !v2_r || !out_stall;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_stall = !en0;
  assign out_valid = v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) s0_r <= in_item;
  end

  rv64_dex_decode u_dec (
    .clk  (clk),
    .en   (en1),
    .item (s0_r),
    .dec_r(dec_r)
  );

  rv64_dex_exec u_exe (
    .clk  (clk),
    .en   (en2),
    .dec  (dec_r),
    .res_r(out_item)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held result changed");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v0_r && v1_r && v2_r && out_stall)
    else $error("input stalled with room");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !out_stall |=> out_valid)
    else $error("item lost between stages");

endmodule

// ===== dv/tb_rv64i_decode_execute_unit.sv =====
`timescale 1ns / 100ps

module tb_rv64i_decode_execute_unit;

  localparam int CLK_PERIOD = 12;
  localparam int NUM_RANDOM = 1700;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SLT = 3'd2;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SRL = 3'd5;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [5:0] HI6_SRA = 6'h10;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  rv64_dex_pkg::in_item_t  in_item;
  logic                    out_valid;
  logic                    out_stall;
  rv64_dex_pkg::out_item_t out_item;

  rv64_dex_pkg::out_item_t exec_results_q[$];
  int        error_count;
  int        result_count;
  int        insn_count;
  bit        stim_done;

  rv64i_decode_execute_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [63:0] sext_bits(input logic [63:0] v, input int bits);
    logic [63:0] m;
    m = 64'd1 << (bits - 1);
    if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
    return (v ^ m) - m;
  endfunction

  function automatic rv64_dex_pkg::out_item_t execute_insn(input rv64_dex_pkg::in_item_t it);
    rv64_dex_pkg::out_item_t r;
    logic [31:0] iw;
    logic [63:0] a, b, imm_i, imm_s, imm_b, imm_u, imm_j;
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [5:0]  sh, hi6;
    bit          ok;
    iw = it.instruction_word;
    a = it.rs1_value;
    b = it.rs2_value;
    opc = iw[6:0];
    f3 = iw[14:12];
    f7 = iw[31:25];
    hi6 = iw[31:26];
    imm_i = sext_bits({52'd0, iw[31:20]}, 12);
    imm_s = sext_bits({52'd0, iw[31:25], iw[11:7]}, 12);
    imm_b = sext_bits({51'd0, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0}, 13);
    imm_u = sext_bits({32'd0, iw[31:12], 12'd0}, 32);
    imm_j = sext_bits({43'd0, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0}, 21);
    r = '0;
    r.dest_reg = iw[11:7];
    ok = 1'b1;
    case (opc)
      rv64_dex_pkg::OPC_OP: begin
        sh = b[5:0];
        r.write_enable = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD: r.result_value = a + b;
            F3_SLL: r.result_value = a << sh;
            F3_SLT: r.result_value = {63'd0, $signed(a) < $signed(b)};
            F3_XOR: r.result_value = a ^ b;
            F3_SRL: r.result_value = a >> sh;
            F3_OR:  r.result_value = a | b;
            F3_AND: r.result_value = a & b;
            default: ok = 1'b0;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          r.result_value = a - b;
        end else if (f7 == F7_ALT && f3 == F3_SRL) begin
          r.result_value = $signed(a) >>> sh;
        end else begin
          ok = 1'b0;
        end
      end
      rv64_dex_pkg::OPC_OPIMM: begin
        sh = imm_i[5:0];
        r.write_enable = 1'b1;
        case (f3)
          F3_ADD: r.result_value = a + imm_i;
          F3_SLT: r.result_value = {63'd0, $signed(a) < $signed(imm_i)};
          F3_XOR: r.result_value = a ^ imm_i;
          F3_OR:  r.result_value = a | imm_i;
          F3_AND: r.result_value = a & imm_i;
          F3_SLL: begin
            if (hi6 == 6'd0) r.result_value = a << sh;
            else ok = 1'b0;
          end
          F3_SRL: begin
            if (hi6 == 6'd0) r.result_value = a >> sh;
            else if (hi6 == HI6_SRA) r.result_value = $signed(a) >>> sh;
            else ok = 1'b0;
          end
          default: ok = 1'b0;
        endcase
      end
      rv64_dex_pkg::OPC_OPW: begin
        r.write_enable = 1'b1;
        if (f3 == F3_ADD && f7 == F7_BASE) r.result_value = sext_bits(a + b, 32);
        else if (f3 == F3_ADD && f7 == F7_ALT) r.result_value = sext_bits(a - b, 32);
        else ok = 1'b0;
      end
      rv64_dex_pkg::OPC_OPIMMW: begin
        r.write_enable = 1'b1;
        if (f3 == F3_ADD) r.result_value = sext_bits(a + imm_i, 32);
        else ok = 1'b0;
      end
      rv64_dex_pkg::OPC_LOAD: begin
        r.write_enable = 1'b1;
        r.load_request = 1'b1;
        r.mem_address = a + imm_i;
      end
      rv64_dex_pkg::OPC_STORE: begin
        r.store_request = 1'b1;
        r.mem_address = a + imm_s;
        r.store_data = b;
      end
      rv64_dex_pkg::OPC_BRANCH: begin
        r.branch_target = it.pc + imm_b;
        case (f3)
          rv64_dex_pkg::BR_EQ: r.branch_taken = (a == b);
          rv64_dex_pkg::BR_NE: r.branch_taken = (a != b);
          rv64_dex_pkg::BR_LT: r.branch_taken = $signed(a) < $signed(b);
          rv64_dex_pkg::BR_GE: r.branch_taken = !($signed(a) < $signed(b));
          default: ok = 1'b0;
        endcase
      end
      rv64_dex_pkg::OPC_JAL: begin
        r.write_enable = 1'b1;
        r.result_value = it.pc + rv64_dex_pkg::INSN_BYTES;
        r.branch_taken = 1'b1;
        r.branch_target = it.pc + imm_j;
      end
      rv64_dex_pkg::OPC_JALR: begin
        if (f3 == F3_ADD) begin
          r.write_enable = 1'b1;
          r.result_value = it.pc + rv64_dex_pkg::INSN_BYTES;
          r.branch_taken = 1'b1;
          r.branch_target = (a + imm_i) & ~64'd1;
        end else begin
          ok = 1'b0;
        end
      end
      rv64_dex_pkg::OPC_LUI: begin
        r.write_enable = 1'b1;
        r.result_value = imm_u;
      end
      rv64_dex_pkg::OPC_AUIPC: begin
        r.write_enable = 1'b1;
        r.result_value = it.pc + imm_u;
      end
      default: ok = 1'b0;
    endcase
    if (!ok) r = '0;
    else if (!r.write_enable) r.dest_reg = 5'd0;
    return r;
  endfunction

  typedef struct {
    rv64_dex_pkg::in_item_t  stim;
    bit                      has_fixed;
    rv64_dex_pkg::out_item_t fixed;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                        input logic [6:0] opc);
    return {f7, 5'd2, 5'd1, f3, 5'd5, opc};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [2:0] f3,
                                        input logic [6:0] opc);
    return {imm, 5'd1, f3, 5'd7, opc};
  endfunction

  task automatic add_row(input logic [31:0] iw, input logic [63:0] pc,
                         input logic [63:0] a, input logic [63:0] b);
    directed_row_t row;
    row.stim.instruction_word = iw;
    row.stim.pc = pc;
    row.stim.rs1_value = a;
    row.stim.rs2_value = b;
    row.has_fixed = 1'b0;
    row.fixed = '0;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed_rows();
    directed_row_t row;
    logic [63:0] mx, mn;
    mx = 64'h7FFF_FFFF_FFFF_FFFF;
    mn = 64'h8000_0000_0000_0000;
    // An unknown opcode with every other bit set clears every output field.
    row.stim = '{32'hFFFF_FFFF, '1, '1, '1};
    row.has_fixed = 1'b1;
    row.fixed = '0;
    directed_rows.push_back(row);
    // LUI with all-ones immediate, written to register zero.
    row.stim = '{{20'hFFFFF, 5'd0, rv64_dex_pkg::OPC_LUI}, '0, '0, '0};
    row.fixed = '0;
    row.fixed.result_value = 64'hFFFF_FFFF_FFFF_F000;
    row.fixed.write_enable = 1'b1;
    directed_rows.push_back(row);
    add_row(enc_r(F7_BASE, F3_ADD, rv64_dex_pkg::OPC_OP), 0, mx, 64'd1);
    add_row(enc_r(F7_ALT, F3_ADD, rv64_dex_pkg::OPC_OP), 0, mn, 64'd1);
    add_row(enc_r(F7_BASE, F3_SLL, rv64_dex_pkg::OPC_OP), 0, '1, 64'hFF);
    add_row(enc_r(F7_BASE, F3_SLT, rv64_dex_pkg::OPC_OP), 0, mn, mx);
    add_row(enc_r(F7_BASE, F3_XOR, rv64_dex_pkg::OPC_OP), 0, mn, '1);
    add_row(enc_r(F7_BASE, F3_SRL, rv64_dex_pkg::OPC_OP), 0, mn, 64'd63);
    add_row(enc_r(F7_ALT, F3_SRL, rv64_dex_pkg::OPC_OP), 0, mn, 64'd63);
    add_row(enc_r(F7_BASE, F3_OR, rv64_dex_pkg::OPC_OP), 0, mn, 64'd5);
    add_row(enc_r(F7_BASE, F3_AND, rv64_dex_pkg::OPC_OP), 0, '1, mx);
    add_row(enc_i(12'hFFF, F3_ADD, rv64_dex_pkg::OPC_OPIMM), 0, mn, 0);
    add_row(enc_i({HI6_SRA, 6'd63}, F3_SRL, rv64_dex_pkg::OPC_OPIMM), 0, mn, 0);
    add_row(enc_i(12'h03F, F3_SLL, rv64_dex_pkg::OPC_OPIMM), 0, 64'd1, 0);
    add_row(enc_r(F7_BASE, F3_ADD, rv64_dex_pkg::OPC_OPW), 0, 64'h7FFF_FFFF, 64'd1);
    add_row(enc_r(F7_ALT, F3_ADD, rv64_dex_pkg::OPC_OPW), 0, 64'd0, 64'd1);
    add_row(enc_i(12'h7FF, F3_ADD, rv64_dex_pkg::OPC_OPIMMW), 0, 64'h7FFF_FFFF, 0);
    add_row(enc_i(12'h800, 3'd7, rv64_dex_pkg::OPC_LOAD), 0, '1, 0);
    add_row({7'h7F, 5'd2, 5'd1, 3'd5, 5'h1F, rv64_dex_pkg::OPC_STORE}, 0, 0, mn);
    add_row({7'h7F, 5'd2, 5'd1, rv64_dex_pkg::BR_GE, 5'h1F, rv64_dex_pkg::OPC_BRANCH},
            64'd16, mn, mx);
    add_row({7'h00, 5'd2, 5'd1, rv64_dex_pkg::BR_EQ, 5'h00, rv64_dex_pkg::OPC_BRANCH},
            '1, 0, 1);
    add_row({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd3, rv64_dex_pkg::OPC_JAL}, '1, 0, 0);
    add_row(enc_i(12'h001, F3_ADD, rv64_dex_pkg::OPC_JALR), 64'd8, '1, 0);
    add_row({20'h80000, 5'd4, rv64_dex_pkg::OPC_AUIPC}, mx, 0, 0);
    add_row(enc_r(F7_BASE, 3'd3, rv64_dex_pkg::OPC_OP), 0, 1, 2);
  endtask

  function automatic rv64_dex_pkg::in_item_t random_insn();
    rv64_dex_pkg::in_item_t it;
    logic [31:0] iw;
    logic [6:0]  opcs[11];
    opcs = '{rv64_dex_pkg::OPC_OP, rv64_dex_pkg::OPC_OPIMM, rv64_dex_pkg::OPC_OPW,
             rv64_dex_pkg::OPC_OPIMMW, rv64_dex_pkg::OPC_LOAD, rv64_dex_pkg::OPC_STORE,
             rv64_dex_pkg::OPC_BRANCH, rv64_dex_pkg::OPC_JAL, rv64_dex_pkg::OPC_JALR,
             rv64_dex_pkg::OPC_LUI, rv64_dex_pkg::OPC_AUIPC};
    iw = $urandom;
    if ($urandom_range(0, 9) != 0) iw[6:0] = opcs[$urandom_range(0, 10)];
    if ($urandom_range(0, 2) == 0) iw[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
    if (iw[6:0] == rv64_dex_pkg::OPC_OPIMM && $urandom_range(0, 1)) begin
      iw[31:26] = $urandom_range(0, 1) ? HI6_SRA : 6'd0;
    end
    it.instruction_word = iw;
    it.pc = {$urandom, $urandom};
    it.rs1_value = {$urandom, $urandom};
    it.rs2_value = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: it.rs2_value = it.rs1_value;
      1: it.rs1_value = {{32{it.rs1_value[31]}}, it.rs1_value[31:0]};
      2: it.rs2_value = 64'($urandom_range(0, 80));
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_insn(input rv64_dex_pkg::in_item_t it, input bit has_fixed,
                           input rv64_dex_pkg::out_item_t fixed);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    exec_results_q.push_back(has_fixed ? fixed : execute_insn(it));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    insn_count++;
    @(negedge clk);
  endtask

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = $urandom_range(0, 18);
      if (!stim_done && $urandom_range(0, 3) == 0 && hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exec_results_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        error_count++;
      end else begin
        if (out_item !== exec_results_q[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, exec_results_q[0],
                   out_item);
          error_count++;
        end
        void'(exec_results_q.pop_front());
      end
      result_count++;
    end
  end

  initial begin
    in_valid = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    error_count = 0;
    result_count = 0;
    insn_count = 0;
    stim_done = 1'b0;
    build_directed_rows();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      send_insn(directed_rows[i].stim, directed_rows[i].has_fixed, directed_rows[i].fixed);
    end
    in_valid <= 1'b0;
    while (exec_results_q.size() != 0) @(negedge clk);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_insn(random_insn(), 1'b0, '0);
      if (i == NUM_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (exec_results_q.size() != 0) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (exec_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d instructions over all supported opcodes and malformed encodings,",
             insn_count);
    $display("with %0d results checked under random input gaps and output stalls.",
             result_count);
    if (error_count == 0 && exec_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 400000);
    $display("Timeout with %0d results outstanding.", exec_results_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rv64_dex_pkg.sv
hdl/rv64_dex_decode.sv
hdl/rv64_dex_exec.sv
hdl/rv64i_decode_execute_unit.sv
dv/tb_rv64i_decode_execute_unit.sv
